// ----- design/bcgt_pkg.sv -----
package bcgt_pkg;

	// Register indexes on the configuration port.
	localparam logic [1:0] RegAreaMin      = 2'd0;
	localparam logic [1:0] RegAreaMax      = 2'd1;
	localparam logic [1:0] RegGateDistance = 2'd2;

	localparam int AreaBits   = 24;
	localparam int GateBits   = 15;
	localparam int PosBits    = 16;
	localparam int RadiusBits = 7;
	localparam int QuotBits   = 15;
	localparam int CfgIdxBits = 2;

	localparam logic [AreaBits-1:0] AreaMinReset = 24'd50;
	localparam logic [AreaBits-1:0] AreaMaxReset = 24'd500;
	localparam logic [GateBits-1:0] GateReset    = 15'd960;

	localparam logic [QuotBits-1:0] PosMax = 15'h7fff;

	// floor(a / 1000) = (a * Rcp1000) >> Rcp1000Shift, exact for any 24-bit a.
	localparam int Rcp1000Bits  = 25;
	localparam int Rcp1000Shift = 34;
	localparam logic [Rcp1000Bits-1:0] Rcp1000 = 25'd17179870;
	localparam int Prod1000Bits = AreaBits + Rcp1000Bits;
	localparam int Quot1000Bits = Prod1000Bits - Rcp1000Shift;
	localparam logic [9:0] Thousand = 10'd1000;

	// floor(r / 10) = (r * Rcp10) >> Rcp10Shift, exact for any r below 1024.
	localparam int RemBits     = 10;
	localparam int Rcp10Bits   = 11;
	localparam int Rcp10Shift  = 14;
	localparam logic [Rcp10Bits-1:0] Rcp10 = 11'd1639;
	localparam int Prod10Bits  = RemBits + Rcp10Bits;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIVIDE,
		S_TRACK,
		S_RAD1,
		S_RAD2,
		S_RAD3,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic clear_track;
		logic div_load;
		logic div_step;
		logic track;
		logic rad1;
		logic rad2;
		logic rad3;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic in_window;
		logic div_busy;
	} status_t;

endpackage

// ----- design/bcgt_if.sv -----
interface bcgt_in_if #(
	parameter int MOMENT_BITS = 32
);
	logic                   valid;
	logic                   ready;
	logic [23:0]            area_moment;
	logic [MOMENT_BITS-1:0] x_moment;
	logic [MOMENT_BITS-1:0] y_moment;

	modport source (output valid, area_moment, x_moment, y_moment, input ready);
	modport sink   (input valid, area_moment, x_moment, y_moment, output ready);
endinterface

interface bcgt_out_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [6:0]         marker_radius;

	modport source (output valid, found, pos_x, pos_y, marker_radius, input ready);
	modport sink   (input valid, found, pos_x, pos_y, marker_radius, output ready);
endinterface

// ----- design/blob_centroid_gated_tracker_core.sv -----
// Blob centroid tracker with per-axis jump gating. Each input word carries
// one frame's zeroth moment (area) and first moments along x and y. When the
// area lies strictly between area_min and area_max, the block divides each
// first moment, scaled by 2^FRAC_BITS, by the area to get the centroid in
// fixed point, saturated at 32767. With no track yet the new centroid starts
// one; if either axis jumps farther than gate_distance from the last
// position, the last position and area are reported again instead. Each
// input word gives exactly one output word: found, pos_x, pos_y and a marker
// radius of (used area / 10) mod 100. Outside the window found is 0, both
// positions read -2^FRAC_BITS and the track is cleared. An in-window word
// passes from acceptance through the window check, the division, the gate
// step and the radius steps to the output register; the bit-serial
// dividers produce one quotient bit per cycle for both axes side by side.
// An out-of-window word goes from the window check straight to the output
// register. The controller returns to its idle state before it takes the
// next word, and waits to fill the output register while it is still
// full and not read. One word is worked on at a time, and the next one is
// accepted while the previous result still waits in the output register.
// Configuration writes are meant for idle periods only.
module blob_centroid_gated_tracker_core #(
	parameter int FRAC_BITS   = 4,
	parameter int MOMENT_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	bcgt_in_if.sink                             in_ch,
	bcgt_out_if.source                          out_ch,
	input  logic                                cfg_we,
	input  logic [bcgt_pkg::CfgIdxBits-1:0]     cfg_index,
	input  logic [bcgt_pkg::AreaBits-1:0]       cfg_data
);

	bcgt_pkg::cmd_t    cmd;
	bcgt_pkg::status_t status;

	// The controller sequences capture, window check, division, gating and
	// the radius arithmetic; the datapath holds every value.
	bcgt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bcgt_datapath #(
		.FRAC_BITS   (FRAC_BITS),
		.MOMENT_BITS (MOMENT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.area_moment   (in_ch.area_moment),
		.x_moment      (in_ch.x_moment),
		.y_moment      (in_ch.y_moment),
		.found         (out_ch.found),
		.pos_x         (out_ch.pos_x),
		.pos_y         (out_ch.pos_y),
		.marker_radius (out_ch.marker_radius)
	);

endmodule

// ----- design/bcgt_divider.sv -----
// Restoring divider, one quotient bit per step, with the quotient saturated
// to fifteen bits.
module bcgt_divider #(
	parameter int NUM_BITS = 36
) (
	input  logic                              clk,
	input  logic                              load,
	input  logic                              step,
	input  logic [NUM_BITS-1:0]               num,
	input  logic [bcgt_pkg::AreaBits-1:0]     den,
	output logic [bcgt_pkg::QuotBits-1:0]     quot
);

	logic [NUM_BITS-1:0]               num_q;
	logic [bcgt_pkg::AreaBits-1:0]     den_q;
	logic [bcgt_pkg::AreaBits-1:0]     rem_q;
	logic [bcgt_pkg::QuotBits-1:0]     quot_q;
	logic                              sat_q;
	logic [bcgt_pkg::AreaBits:0]       trial;
	logic                              fits;

	assign trial = {rem_q, num_q[NUM_BITS-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (load) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
			sat_q  <= 1'b0;
		end else if (step) begin
			num_q  <= num_q << 1;
			rem_q  <= fits ? bcgt_pkg::AreaBits'(trial - {1'b0, den_q})
			               : trial[bcgt_pkg::AreaBits-1:0];
			quot_q <= {quot_q[bcgt_pkg::QuotBits-2:0], fits};
			sat_q  <= sat_q | quot_q[bcgt_pkg::QuotBits-1];
		end
	end

	assign quot = sat_q ? bcgt_pkg::PosMax : quot_q;

endmodule

// ----- design/bcgt_datapath.sv -----
module bcgt_datapath #(
	parameter int FRAC_BITS   = 4,
	parameter int MOMENT_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bcgt_pkg::cmd_t                        cmd,
	output bcgt_pkg::status_t                     status,
	input  logic                                  cfg_we,
	input  logic [bcgt_pkg::CfgIdxBits-1:0]       cfg_index,
	input  logic [bcgt_pkg::AreaBits-1:0]         cfg_data,
	input  logic [bcgt_pkg::AreaBits-1:0]         area_moment,
	input  logic [MOMENT_BITS-1:0]                x_moment,
	input  logic [MOMENT_BITS-1:0]                y_moment,
	output logic                                  found,
	output logic signed [bcgt_pkg::PosBits-1:0]   pos_x,
	output logic signed [bcgt_pkg::PosBits-1:0]   pos_y,
	output logic [bcgt_pkg::RadiusBits-1:0]       marker_radius
);

	localparam int NumBits = MOMENT_BITS + FRAC_BITS;
	localparam int CntBits = $clog2(NumBits + 1);
	localparam logic [bcgt_pkg::PosBits-1:0] PosNone =
		bcgt_pkg::PosBits'(-(1 << FRAC_BITS));

	// Configuration registers.
	logic [bcgt_pkg::AreaBits-1:0] area_min_q;
	logic [bcgt_pkg::AreaBits-1:0] area_max_q;
	logic [bcgt_pkg::GateBits-1:0] gate_q;

	// Captured word.
	logic [bcgt_pkg::AreaBits-1:0] area_q;
	logic [MOMENT_BITS-1:0]        x_mom_q;
	logic [MOMENT_BITS-1:0]        y_mom_q;

	// Track state.
	logic [bcgt_pkg::PosBits-1:0]  last_x_q;
	logic [bcgt_pkg::PosBits-1:0]  last_y_q;
	logic [bcgt_pkg::AreaBits-1:0] last_area_q;

	logic [CntBits-1:0]            cnt_q;
	logic [bcgt_pkg::QuotBits-1:0] quot_x;
	logic [bcgt_pkg::QuotBits-1:0] quot_y;

	// Result being built and the output register.
	logic                                res_found_q;
	logic [bcgt_pkg::PosBits-1:0]        res_x_q;
	logic [bcgt_pkg::PosBits-1:0]        res_y_q;
	logic [bcgt_pkg::RadiusBits-1:0]     res_radius_q;
	logic [bcgt_pkg::AreaBits-1:0]       used_area_q;
	logic [bcgt_pkg::Prod1000Bits-1:0]   prod1000_q;
	logic [bcgt_pkg::RemBits-1:0]        rem_q;
	logic                                out_found_q;
	logic [bcgt_pkg::PosBits-1:0]        out_x_q;
	logic [bcgt_pkg::PosBits-1:0]        out_y_q;
	logic [bcgt_pkg::RadiusBits-1:0]     out_radius_q;

	logic [bcgt_pkg::PosBits-1:0]        px;
	logic [bcgt_pkg::PosBits-1:0]        py;
	logic [bcgt_pkg::PosBits-1:0]        ref_x;
	logic [bcgt_pkg::PosBits-1:0]        ref_y;
	logic                                fresh;
	logic                                jump;
	logic [bcgt_pkg::PosBits-1:0]        sel_x;
	logic [bcgt_pkg::PosBits-1:0]        sel_y;
	logic [bcgt_pkg::AreaBits-1:0]       sel_area;
	logic [bcgt_pkg::Quot1000Bits-1:0]   quot1000;
	logic [bcgt_pkg::Prod10Bits-1:0]     prod10;

	// True when |now - prev| exceeds the gate, both taken as signed.
	function automatic logic jumped(input logic [bcgt_pkg::PosBits-1:0] now,
	                                input logic [bcgt_pkg::PosBits-1:0] prev,
	                                input logic [bcgt_pkg::GateBits-1:0] gate);
		logic [bcgt_pkg::PosBits:0] diff;
		logic [bcgt_pkg::PosBits:0] mag;
		diff = {now[bcgt_pkg::PosBits-1], now} - {prev[bcgt_pkg::PosBits-1], prev};
		mag  = diff[bcgt_pkg::PosBits] ? (~diff + 1'b1) : diff;
		return mag > {2'b00, gate};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_min_q <= bcgt_pkg::AreaMinReset;
			area_max_q <= bcgt_pkg::AreaMaxReset;
			gate_q     <= bcgt_pkg::GateReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcgt_pkg::RegAreaMin:      area_min_q <= cfg_data;
				bcgt_pkg::RegAreaMax:      area_max_q <= cfg_data;
				bcgt_pkg::RegGateDistance: gate_q     <= cfg_data[bcgt_pkg::GateBits-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			area_q  <= area_moment;
			x_mom_q <= x_moment;
			y_mom_q <= y_moment;
		end
	end

	assign status.in_window = (area_q > area_min_q) && (area_q < area_max_q);
	assign status.div_busy  = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_load) begin
			cnt_q <= CntBits'(NumBits);
		end else if (cmd.div_step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	bcgt_divider #(.NUM_BITS(NumBits)) u_div_x (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step && cnt_q != '0),
		.num  (NumBits'(x_mom_q) << FRAC_BITS),
		.den  (area_q),
		.quot (quot_x)
	);

	bcgt_divider #(.NUM_BITS(NumBits)) u_div_y (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step && cnt_q != '0),
		.num  (NumBits'(y_mom_q) << FRAC_BITS),
		.den  (area_q),
		.quot (quot_y)
	);

	// Gate decision on the fresh quotients.
	assign px       = {1'b0, quot_x};
	assign py       = {1'b0, quot_y};
	assign fresh    = (last_x_q == PosNone) || (last_y_q == PosNone);
	assign ref_x    = fresh ? px : last_x_q;
	assign ref_y    = fresh ? py : last_y_q;
	assign jump     = jumped(px, ref_x, gate_q) || jumped(py, ref_y, gate_q);
	assign sel_x    = jump ? ref_x : px;
	assign sel_y    = jump ? ref_y : py;
	assign sel_area = jump ? last_area_q : area_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q    <= PosNone;
			last_y_q    <= PosNone;
			last_area_q <= '0;
		end else if (cmd.clear_track) begin
			last_x_q <= PosNone;
			last_y_q <= PosNone;
		end else if (cmd.track) begin
			last_x_q    <= sel_x;
			last_y_q    <= sel_y;
			last_area_q <= sel_area;
		end
	end

	// Marker radius: (used area / 10) mod 100, taken as (area mod 1000) / 10.
	assign quot1000 = prod1000_q[bcgt_pkg::Prod1000Bits-1:bcgt_pkg::Rcp1000Shift];
	assign prod10   = bcgt_pkg::Prod10Bits'(rem_q) * bcgt_pkg::Prod10Bits'(bcgt_pkg::Rcp10);

	always_ff @(posedge clk) begin
		if (cmd.clear_track) begin
			res_found_q  <= 1'b0;
			res_x_q      <= PosNone;
			res_y_q      <= PosNone;
			res_radius_q <= '0;
		end else if (cmd.track) begin
			res_found_q <= 1'b1;
			res_x_q     <= sel_x;
			res_y_q     <= sel_y;
			used_area_q <= sel_area;
		end
		if (cmd.rad1) begin
			prod1000_q <= bcgt_pkg::Prod1000Bits'(used_area_q)
			            * bcgt_pkg::Prod1000Bits'(bcgt_pkg::Rcp1000);
		end
		if (cmd.rad2) begin
			rem_q <= bcgt_pkg::RemBits'(used_area_q
			       - bcgt_pkg::AreaBits'(quot1000 * bcgt_pkg::Quot1000Bits'(bcgt_pkg::Thousand)));
		end
		if (cmd.rad3) begin
			res_radius_q <= bcgt_pkg::RadiusBits'(prod10 >> bcgt_pkg::Rcp10Shift);
		end
		if (cmd.emit) begin
			out_found_q  <= res_found_q;
			out_x_q      <= res_x_q;
			out_y_q      <= res_y_q;
			out_radius_q <= res_radius_q;
		end
	end

	assign found         = out_found_q;
	assign pos_x         = out_x_q;
	assign pos_y         = out_y_q;
	assign marker_radius = out_radius_q;

endmodule

// ----- design/bcgt_ctrl.sv -----
module bcgt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bcgt_pkg::status_t status,
	output bcgt_pkg::cmd_t    cmd
);

	bcgt_pkg::state_t state_q;
	bcgt_pkg::state_t state_next;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcgt_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			bcgt_pkg::S_IDLE:   if (in_valid) state_next = bcgt_pkg::S_CHECK;
			bcgt_pkg::S_CHECK: begin
				state_next = status.in_window ? bcgt_pkg::S_DIVIDE : bcgt_pkg::S_EMIT;
			end
			bcgt_pkg::S_DIVIDE: if (!status.div_busy) state_next = bcgt_pkg::S_TRACK;
			bcgt_pkg::S_TRACK:  state_next = bcgt_pkg::S_RAD1;
			bcgt_pkg::S_RAD1:   state_next = bcgt_pkg::S_RAD2;
			bcgt_pkg::S_RAD2:   state_next = bcgt_pkg::S_RAD3;
			bcgt_pkg::S_RAD3:   state_next = bcgt_pkg::S_EMIT;
			bcgt_pkg::S_EMIT:   if (slot_free) state_next = bcgt_pkg::S_IDLE;
			default:            state_next = bcgt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			bcgt_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			bcgt_pkg::S_CHECK: begin
				cmd.div_load    = status.in_window;
				cmd.clear_track = !status.in_window;
			end
			bcgt_pkg::S_DIVIDE: cmd.div_step = 1'b1;
			bcgt_pkg::S_TRACK:  cmd.track    = 1'b1;
			bcgt_pkg::S_RAD1:   cmd.rad1     = 1'b1;
			bcgt_pkg::S_RAD2:   cmd.rad2     = 1'b1;
			bcgt_pkg::S_RAD3:   cmd.rad3     = 1'b1;
			bcgt_pkg::S_EMIT:   cmd.emit     = slot_free;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
